@@ rtl/imhq_pkg.sv @@
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed min-heap priority queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int ID_BITS      = 8;
  localparam int NUM_IDS      = 256;
  localparam int IN_KEY_BITS  = 32;
  localparam int OUT_KEY_BITS = 32;
  localparam int OCC_BITS     = 9;

  typedef enum logic [1:0] {
    REQ_INSERT,
    REQ_UPDATE,
    REQ_REMOVE,
    REQ_EXTRACT
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_FULL,
    STAT_ABSENT,
    STAT_EMPTY,
    STAT_PRESENT
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPD_RD,
    S_TAKE_RD,
    S_TAKE_LAST,
    S_UP_REQ,
    S_UP_CMP,
    S_DOWN_REQ,
    S_DOWN_RD1,
    S_DOWN_RD2,
    S_DOWN_CMP,
    S_PLACE,
    S_FINISH
  } state_t;

endpackage

@@ rtl/imhq_heap_mem.sv @@
// ----------------------------------------------------------------------------
// imhq_heap_mem
// Heap slot memory holding an item and its key per slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module imhq_heap_mem #(
  parameter int SLOT_BITS = 9,
  parameter int KEY_BITS  = 32,
  parameter int DEPTH     = 257
) (
  input  logic                         clk,
  input  logic [SLOT_BITS-1:0]         raddr,
  output logic [imhq_pkg::ID_BITS-1:0] rd_id,
  output logic [KEY_BITS-1:0]          rd_key,
  input  logic                         we,
  input  logic [SLOT_BITS-1:0]         waddr,
  input  logic [imhq_pkg::ID_BITS-1:0] wr_id,
  input  logic [KEY_BITS-1:0]          wr_key
);

  logic [imhq_pkg::ID_BITS-1:0] ids  [DEPTH];
  logic [KEY_BITS-1:0]          keys [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ids[waddr]  <= wr_id;
      keys[waddr] <= wr_key;
    end
    rd_id  <= ids[raddr];
    rd_key <= keys[raddr];
  end

endmodule

@@ rtl/imhq_pos_mem.sv @@
// ----------------------------------------------------------------------------
// imhq_pos_mem
// Position table from item to heap slot. A cleared valid bit reads as slot
// zero, which means the item is absent.
// ----------------------------------------------------------------------------
module imhq_pos_mem #(
  parameter int SLOT_BITS = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [imhq_pkg::ID_BITS-1:0] raddr,
  output logic [SLOT_BITS-1:0]         rdata,
  input  logic                         we,
  input  logic [imhq_pkg::ID_BITS-1:0] waddr,
  input  logic [SLOT_BITS-1:0]         wdata
);

  logic [SLOT_BITS-1:0]         slots [imhq_pkg::NUM_IDS];
  logic [imhq_pkg::NUM_IDS-1:0] valid;
  logic [SLOT_BITS-1:0]         rd_slot;
  logic                         rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
    rd_slot <= slots[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= (wdata != '0);
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_slot : '0;

endmodule

@@ rtl/indexed_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of item IDs with keys: insert, update key, remove
// item and extract minimum, one result item per request item.
// ----------------------------------------------------------------------------
// Each request takes one item at a time through a sequencer built around a
// single-read-port heap memory. A request passes through a lookup, walks the
// heap up or down level by level and then wraps up; an error goes from the
// lookup straight to wrap-up.
// The next request item is taken as soon as the sequencer is back in idle,
// even while the last result still waits in the output register.
module indexed_min_heap_queue #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [imhq_pkg::ID_BITS-1:0]      item_id,
  input  logic [imhq_pkg::IN_KEY_BITS-1:0]  key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imhq_pkg::ID_BITS-1:0]      out_item,
  output logic [imhq_pkg::OUT_KEY_BITS-1:0] out_key,
  output logic [imhq_pkg::OCC_BITS-1:0]     occupancy,
  output logic [2:0]                        status
);

  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int DEPTH = CAPACITY + 1;
  localparam logic [SW-1:0] CAP_SLOT = SW'(CAPACITY);
  localparam logic [SW-1:0] ROOT     = SW'(1);

  imhq_pkg::state_t  state, state_next;
  imhq_pkg::req_t    req, req_next;
  imhq_pkg::status_t res_status, res_status_next;

  logic [imhq_pkg::ID_BITS-1:0]      id_r, id_r_next;
  logic [KEY_BITS-1:0]               key_r, key_r_next;
  logic [SW-1:0]                     cnt, cnt_next;
  logic [SW-1:0]                     hole, hole_next;
  logic [imhq_pkg::ID_BITS-1:0]      cur_id, cur_id_next;
  logic [KEY_BITS-1:0]               cur_key, cur_key_next;
  logic [imhq_pkg::ID_BITS-1:0]      child_id, child_id_next;
  logic [KEY_BITS-1:0]               child_key, child_key_next;
  logic [SW-1:0]                     child_slot, child_slot_next;
  logic                              down_after, down_after_next;
  logic                              moved, moved_next;
  logic [imhq_pkg::ID_BITS-1:0]      res_item, res_item_next;
  logic [imhq_pkg::OUT_KEY_BITS-1:0] res_key, res_key_next;
  logic                              out_load;

  logic [SW:0]                       c_wide;
  logic [SW:0]                       cnt_wide;

  logic [SW-1:0]                     heap_raddr;
  logic [imhq_pkg::ID_BITS-1:0]      rd_id;
  logic [KEY_BITS-1:0]               rd_key;
  logic                              heap_we;
  logic [SW-1:0]                     heap_waddr;
  logic [imhq_pkg::ID_BITS-1:0]      wr_id;
  logic [KEY_BITS-1:0]               wr_key;

  logic [imhq_pkg::ID_BITS-1:0]      pos_raddr;
  logic [SW-1:0]                     pos_rdata;
  logic                              pos_we;
  logic [imhq_pkg::ID_BITS-1:0]      pos_waddr;
  logic [SW-1:0]                     pos_wdata;

  imhq_heap_mem #(
    .SLOT_BITS (SW),
    .KEY_BITS  (KEY_BITS),
    .DEPTH     (DEPTH)
  ) u_heap (
    .clk    (clk),
    .raddr  (heap_raddr),
    .rd_id  (rd_id),
    .rd_key (rd_key),
    .we     (heap_we),
    .waddr  (heap_waddr),
    .wr_id  (wr_id),
    .wr_key (wr_key)
  );

  imhq_pos_mem #(
    .SLOT_BITS (SW)
  ) u_pos (
    .clk   (clk),
    .rst   (rst),
    .raddr (pos_raddr),
    .rdata (pos_rdata),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata)
  );

  assign c_wide   = {hole, 1'b0};
  assign cnt_wide = {1'b0, cnt};
  assign in_stall = (state != imhq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imhq_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    id_r       <= id_r_next;
    key_r      <= key_r_next;
    hole       <= hole_next;
    cur_id     <= cur_id_next;
    cur_key    <= cur_key_next;
    child_id   <= child_id_next;
    child_key  <= child_key_next;
    child_slot <= child_slot_next;
    down_after <= down_after_next;
    moved      <= moved_next;
    res_item   <= res_item_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_item  <= res_item;
      out_key   <= res_key;
      occupancy <= imhq_pkg::OCC_BITS'(cnt);
      status    <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    id_r_next       = id_r;
    key_r_next      = key_r;
    cnt_next        = cnt;
    hole_next       = hole;
    cur_id_next     = cur_id;
    cur_key_next    = cur_key;
    child_id_next   = child_id;
    child_key_next  = child_key;
    child_slot_next = child_slot;
    down_after_next = down_after;
    moved_next      = moved;
    res_item_next   = res_item;
    res_key_next    = res_key;
    res_status_next = res_status;
    out_load        = 1'b0;
    heap_raddr      = hole >> 1;
    heap_we         = 1'b0;
    heap_waddr      = hole;
    wr_id           = cur_id;
    wr_key          = cur_key;
    pos_raddr       = item_id;
    pos_we          = 1'b0;
    pos_waddr       = cur_id;
    pos_wdata       = hole;

    unique case (state)
      imhq_pkg::S_IDLE: begin
        if (in_valid) begin
          req_next   = imhq_pkg::req_t'(req_type);
          id_r_next  = item_id;
          key_r_next = KEY_BITS'(key);
          state_next = imhq_pkg::S_LOOKUP;
        end
      end
      imhq_pkg::S_LOOKUP: begin
        res_item_next   = '0;
        res_key_next    = '0;
        res_status_next = imhq_pkg::STAT_OK;
        moved_next      = 1'b0;
        down_after_next = 1'b0;
        unique case (req)
          imhq_pkg::REQ_INSERT: begin
            if (pos_rdata != '0) begin
              res_status_next = imhq_pkg::STAT_PRESENT;
              state_next      = imhq_pkg::S_FINISH;
            end else if (cnt == CAP_SLOT) begin
              res_status_next = imhq_pkg::STAT_FULL;
              state_next      = imhq_pkg::S_FINISH;
            end else begin
              cnt_next     = cnt + 1'b1;
              hole_next    = cnt + 1'b1;
              cur_id_next  = id_r;
              cur_key_next = key_r;
              state_next   = imhq_pkg::S_UP_REQ;
            end
          end
          imhq_pkg::REQ_UPDATE, imhq_pkg::REQ_REMOVE: begin
            if (pos_rdata == '0 || pos_rdata > cnt) begin
              res_status_next = imhq_pkg::STAT_ABSENT;
              state_next      = imhq_pkg::S_FINISH;
            end else begin
              hole_next  = pos_rdata;
              heap_raddr = pos_rdata;
              state_next = (req == imhq_pkg::REQ_UPDATE) ? imhq_pkg::S_UPD_RD
                                                          : imhq_pkg::S_TAKE_RD;
            end
          end
          imhq_pkg::REQ_EXTRACT: begin
            if (cnt == '0) begin
              res_status_next = imhq_pkg::STAT_EMPTY;
              state_next      = imhq_pkg::S_FINISH;
            end else begin
              hole_next  = ROOT;
              heap_raddr = ROOT;
              state_next = imhq_pkg::S_TAKE_RD;
            end
          end
          default: state_next = imhq_pkg::S_FINISH;
        endcase
      end
      imhq_pkg::S_UPD_RD: begin
        cur_id_next  = id_r;
        cur_key_next = key_r;
        state_next   = (rd_key < key_r) ? imhq_pkg::S_DOWN_REQ : imhq_pkg::S_UP_REQ;
      end
      imhq_pkg::S_TAKE_RD: begin
        res_item_next = rd_id;
        res_key_next  = imhq_pkg::OUT_KEY_BITS'(rd_key);
        pos_we        = 1'b1;
        pos_waddr     = rd_id;
        pos_wdata     = '0;
        heap_raddr    = cnt;
        cnt_next      = cnt - 1'b1;
        if (hole == cnt) begin
          state_next = imhq_pkg::S_FINISH;
        end else begin
          down_after_next = 1'b1;
          state_next      = imhq_pkg::S_TAKE_LAST;
        end
      end
      imhq_pkg::S_TAKE_LAST: begin
        // The last item fills the freed slot and is sifted from there.
        cur_id_next  = rd_id;
        cur_key_next = rd_key;
        state_next   = imhq_pkg::S_UP_REQ;
      end
      imhq_pkg::S_UP_REQ: begin
        if (hole == ROOT) begin
          state_next = (down_after && !moved) ? imhq_pkg::S_DOWN_REQ : imhq_pkg::S_PLACE;
        end else begin
          heap_raddr = hole >> 1;
          state_next = imhq_pkg::S_UP_CMP;
        end
      end
      imhq_pkg::S_UP_CMP: begin
        if (rd_key > cur_key) begin
          heap_we    = 1'b1;
          wr_id      = rd_id;
          wr_key     = rd_key;
          pos_we     = 1'b1;
          pos_waddr  = rd_id;
          hole_next  = hole >> 1;
          moved_next = 1'b1;
          state_next = imhq_pkg::S_UP_REQ;
        end else begin
          state_next = (down_after && !moved) ? imhq_pkg::S_DOWN_REQ : imhq_pkg::S_PLACE;
        end
      end
      imhq_pkg::S_DOWN_REQ: begin
        if (c_wide > cnt_wide) begin
          state_next = imhq_pkg::S_PLACE;
        end else begin
          heap_raddr      = SW'(c_wide);
          child_slot_next = SW'(c_wide);
          state_next      = imhq_pkg::S_DOWN_RD1;
        end
      end
      imhq_pkg::S_DOWN_RD1: begin
        child_id_next  = rd_id;
        child_key_next = rd_key;
        if (c_wide + 1'b1 <= cnt_wide) begin
          heap_raddr = SW'(c_wide + 1'b1);
          state_next = imhq_pkg::S_DOWN_RD2;
        end else begin
          state_next = imhq_pkg::S_DOWN_CMP;
        end
      end
      imhq_pkg::S_DOWN_RD2: begin
        if (rd_key < child_key) begin
          child_id_next   = rd_id;
          child_key_next  = rd_key;
          child_slot_next = child_slot + 1'b1;
        end
        state_next = imhq_pkg::S_DOWN_CMP;
      end
      imhq_pkg::S_DOWN_CMP: begin
        if (child_key < cur_key) begin
          heap_we    = 1'b1;
          wr_id      = child_id;
          wr_key     = child_key;
          pos_we     = 1'b1;
          pos_waddr  = child_id;
          hole_next  = child_slot;
          state_next = imhq_pkg::S_DOWN_REQ;
        end else begin
          state_next = imhq_pkg::S_PLACE;
        end
      end
      imhq_pkg::S_PLACE: begin
        heap_we    = 1'b1;
        pos_we     = 1'b1;
        state_next = imhq_pkg::S_FINISH;
      end
      imhq_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = imhq_pkg::S_IDLE;
        end
      end
      default: state_next = imhq_pkg::S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_SLOT)
    else $error("item count exceeds capacity");

  a_pos_tracks_heap: assert property (@(posedge clk) disable iff (rst)
    (pos_we && pos_wdata != '0) |-> (heap_we && heap_waddr == pos_wdata && wr_id == pos_waddr))
    else $error("position table write does not match heap write");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == imhq_pkg::S_LOOKUP))
    else $error("accepted item did not start a lookup");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == imhq_pkg::S_FINISH && !(out_valid && out_stall))
      |=> (out_valid && state == imhq_pkg::S_IDLE))
    else $error("finished request did not produce a result");

endmodule
